// File: rtl/ilid_pkg.sv
// ---------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list
// Request kinds, response codes, cell commands and field widths used by
// the list controller, the storage cells and the top level.
// ---------------------------------------------------------------------------
package ilid_pkg;

   // Fixed field widths
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   // Capacity range and the index width that covers every legal capacity
   localparam int CAP_DEFAULT = 8;
   localparam int CAP_MAX     = 64;
   localparam int IDX_W       = $clog2(CAP_MAX + 1);

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND  = 3'd0,
      KIND_INSERT  = 3'd1,
      KIND_REMOVE  = 3'd2,
      KIND_REPLACE = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_WRITE      = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   target;
   } cell_ctl_type;

endpackage

// File: rtl/ilid_cell.sv
// ---------------------------------------------------------------------------
// ilid_cell: one storage slot of the list
// Holds one entry and, on a broadcast command, keeps it, takes the new
// value, or takes the neighbor's entry from below or above.
// ---------------------------------------------------------------------------
module ilid_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  ilid_pkg::cell_ctl_type            ctl,
   input  logic signed [ilid_pkg::DATA_W-1:0] item_value,
   input  logic signed [ilid_pkg::DATA_W-1:0] lower_entry,
   input  logic signed [ilid_pkg::DATA_W-1:0] upper_entry,
   output logic signed [ilid_pkg::DATA_W-1:0] entry
);

   localparam logic [ilid_pkg::IDX_W-1:0] MY_IDX = ilid_pkg::IDX_W'(INDEX);

   logic signed [ilid_pkg::DATA_W-1:0] entry_ff;
   logic signed [ilid_pkg::DATA_W-1:0] entry_in;

   // Pick the next entry from the broadcast command
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         ilid_pkg::CELL_SHIFT_UP: begin
            if (MY_IDX > ctl.target) begin
               entry_in = lower_entry;
            end else if (MY_IDX == ctl.target) begin
               entry_in = item_value;
            end
         end
         ilid_pkg::CELL_SHIFT_DOWN: begin
            if (MY_IDX >= ctl.target) begin
               entry_in = upper_entry;
            end
         end
         ilid_pkg::CELL_WRITE: begin
            if (MY_IDX == ctl.target) begin
               entry_in = item_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Hold the entry
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/ilid_ctrl.sv
// ---------------------------------------------------------------------------
// ilid_ctrl: list controller
// Keeps the entry count, checks each request against it, sets the status
// and broadcasts the shift or write command to the cell row.
// ---------------------------------------------------------------------------
module ilid_ctrl #(
   parameter int CAP = ilid_pkg::CAP_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [ilid_pkg::KIND_W-1:0]     kind,
   input  logic [ilid_pkg::POS_W-1:0]      position,
   output ilid_pkg::cell_ctl_type          ctl,
   output ilid_pkg::status_type            status,
   output logic [ilid_pkg::IDX_W-1:0]      count_next
);

   localparam int CNT_W = $clog2(CAP + 1);
   localparam logic [ilid_pkg::IDX_W-1:0] CAP_IDX = ilid_pkg::IDX_W'(CAP);

   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [ilid_pkg::IDX_W-1:0] cnt_ext;
   logic [ilid_pkg::IDX_W-1:0] pos_ext;
   ilid_pkg::cell_op_type      op;
   logic [ilid_pkg::IDX_W-1:0] target;

   assign cnt_ext = ilid_pkg::IDX_W'(count_ff);
   assign pos_ext = ilid_pkg::IDX_W'(position);

   // Check the request and choose the cell command
   always_comb begin
      status   = ilid_pkg::STATUS_DONE;
      op       = ilid_pkg::CELL_HOLD;
      target   = pos_ext;
      count_in = count_ff;
      case (ilid_pkg::kind_type'(kind))
         ilid_pkg::KIND_APPEND: begin
            if (cnt_ext >= CAP_IDX) begin
               status = ilid_pkg::STATUS_FULL;
            end else begin
               op       = ilid_pkg::CELL_WRITE;
               target   = cnt_ext;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ilid_pkg::KIND_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = ilid_pkg::STATUS_RANGE;
            end else if (cnt_ext >= CAP_IDX) begin
               status = ilid_pkg::STATUS_FULL;
            end else begin
               op       = ilid_pkg::CELL_SHIFT_UP;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ilid_pkg::KIND_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status = ilid_pkg::STATUS_RANGE;
            end else begin
               op       = ilid_pkg::CELL_SHIFT_DOWN;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ilid_pkg::KIND_REPLACE: begin
            if (pos_ext >= cnt_ext) begin
               status = ilid_pkg::STATUS_RANGE;
            end else begin
               op = ilid_pkg::CELL_WRITE;
            end
         end
         ilid_pkg::KIND_READ: begin
            if (pos_ext >= cnt_ext) begin
               status = ilid_pkg::STATUS_RANGE;
            end
         end
         default: begin
            status = ilid_pkg::STATUS_DONE;
         end
      endcase
   end

   // Broadcast only on an accepted request
   always_comb begin
      ctl.op     = fire ? op : ilid_pkg::CELL_HOLD;
      ctl.target = target;
   end

   // Advance the count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   assign count_next = ilid_pkg::IDX_W'(count_in);

endmodule

// File: rtl/indexed_list_insert_delete.sv
// The response is registered and valid in the cycle after a request is
// accepted. Throughput: one request per cycle while responses are taken;
// every cell shifts or writes in the same cycle; the response register
// frees up as it is taken. Reset clears the entry count and the response
// valid; entries stay unknown until written and are never read before that.
// ---------------------------------------------------------------------------
// indexed_list_insert_delete: fixed-capacity ordered list
// A row of cells holds the entries; a controller checks each request,
// moves the row up or down for insert and remove, and reports the result.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete #(
   parameter int CAP = ilid_pkg::CAP_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ilid_pkg::KIND_W-1:0]         req_kind,
   input  logic [ilid_pkg::POS_W-1:0]          req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0]  req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ilid_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ilid_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [ilid_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                                rsp_is_full,
   output logic                                rsp_is_empty
);

   localparam logic [ilid_pkg::IDX_W-1:0] CAP_IDX = ilid_pkg::IDX_W'(CAP);

   logic                               fire;
   ilid_pkg::cell_ctl_type             ctl;
   ilid_pkg::status_type               status;
   logic [ilid_pkg::IDX_W-1:0]         count_next;
   logic [ilid_pkg::IDX_W-1:0]         pos_ext;
   logic signed [ilid_pkg::DATA_W-1:0] entries [CAP];
   logic signed [ilid_pkg::DATA_W-1:0] read_sel;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [ilid_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic signed [ilid_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic [ilid_pkg::COUNT_W-1:0]       rsp_entry_count_ff;
   logic                               rsp_is_full_ff;
   logic                               rsp_is_empty_ff;

   // Take a request whenever the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign pos_ext   = ilid_pkg::IDX_W'(req_position);

   ilid_ctrl #(
      .CAP (CAP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .kind       (req_kind),
      .position   (req_position),
      .ctl        (ctl),
      .status     (status),
      .count_next (count_next)
   );

   // Chain the cells; the ends feed back their own entry
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic signed [ilid_pkg::DATA_W-1:0] lower;
      logic signed [ilid_pkg::DATA_W-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = entries[i];
      end else begin : g_mid_lo
         assign lower = entries[i-1];
      end

      if (i == CAP - 1) begin : g_last
         assign upper = entries[i];
      end else begin : g_mid_hi
         assign upper = entries[i+1];
      end

      ilid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .item_value  (req_item_value),
         .lower_entry (lower),
         .upper_entry (upper),
         .entry       (entries[i])
      );
   end

   // Select the entry at the requested position for a good read
   always_comb begin
      read_sel = '0;
      for (int i = 0; i < CAP; i++) begin
         if (pos_ext == ilid_pkg::IDX_W'(i)) begin
            read_sel = entries[i];
         end
      end
      if (ilid_pkg::kind_type'(req_kind) != ilid_pkg::KIND_READ ||
          status != ilid_pkg::STATUS_DONE) begin
         read_sel = '0;
      end
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff      <= status;
         rsp_read_value_ff  <= read_sel;
         rsp_entry_count_ff <= count_next[ilid_pkg::COUNT_W-1:0];
         rsp_is_full_ff     <= (count_next == CAP_IDX);
         rsp_is_empty_ff    <= (count_next == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_full     = rsp_is_full_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

endmodule
